>>> hw/rtl/hermite_curve_2d_evaluator_macros.svh
`ifndef HERMITE_CURVE_2D_EVALUATOR_MACROS_SVH
`define HERMITE_CURVE_2D_EVALUATOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent; reset masks the check.
`define HCE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent; reset masks the check.
`define HCE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/hce_pkg.sv
package hce_pkg;

   localparam int S_W      = 16;
   localparam logic [S_W-1:0] S_ONE = 16'h8000;

   localparam int COEF_W    = 32;
   localparam int NUM_REGS  = 8;
   localparam int PADDR_W   = 5;
   localparam int OUT_W     = 32;

   // raw derivative and position widths (unsaturated)
   localparam int DER_W     = 35;
   localparam int POS_W     = 35;

   // curvature path widths
   localparam int NUM_W     = 71;
   localparam int MAG_W     = 69;
   localparam int SQ_W      = 69;
   localparam int ROOT_W    = 51;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 3;
   localparam int DEN_W     = 120;
   localparam int DIVREM_W  = DEN_W + 1;
   localparam int Q_W       = 32;

   localparam int POLY_LAT  = 7;
   localparam int CROSS_LAT = 3;
   localparam int SQRT_LAT  = ROOT_W;
   localparam int DIV_LAT   = Q_W + 4;
   localparam int CURV_LAT  = CROSS_LAT + SQRT_LAT + DIV_LAT;

   localparam logic signed [POS_W-1:0] POS_MAX = 35'sd2147483647;
   localparam logic signed [POS_W-1:0] POS_MIN = -35'sd2147483648;

   typedef enum logic [2:0] {
      REG_X3 = 3'd0,
      REG_X2 = 3'd1,
      REG_X1 = 3'd2,
      REG_X0 = 3'd3,
      REG_Y3 = 3'd4,
      REG_Y2 = 3'd5,
      REG_Y1 = 3'd6,
      REG_Y0 = 3'd7
   } reg_idx_type;

   // sideband that travels with an item through the root and divide pipes
   typedef struct packed {
      logic             vld;
      logic             zero;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [SQ_W-1:0]  sq;
   } crv_side_type;

   // saturated position and tangent waiting for the curvature
   typedef struct packed {
      logic [OUT_W-1:0] px;
      logic [OUT_W-1:0] py;
      logic [OUT_W-1:0] tx;
      logic [OUT_W-1:0] ty;
      logic             sat;
   } kin_type;

   // clip to 32 bits; top bit of the result flags a clip
   function automatic logic [OUT_W:0] sat32(input logic signed [POS_W-1:0] v);
      logic [OUT_W:0] r;
      if (v > POS_MAX) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < POS_MIN) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[OUT_W-1:0]};
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/hermite_curve_2d_evaluator.sv
// Throughput: one item per cycle; busy is never raised, the pipeline never stalls.
// The curvature path holds the 51-stage square root and the 36-stage divider.
// Reset clears every valid bit and the eight coefficient registers to zero.
// Results are strobed on rsp_valid for one cycle; the receiver cannot hold them off.
module hermite_curve_2d_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [hce_pkg::S_W-1:0]             req_s_param,
   output logic                                rsp_valid,
   output logic signed [hce_pkg::OUT_W-1:0]    rsp_pos_x,
   output logic signed [hce_pkg::OUT_W-1:0]    rsp_pos_y,
   output logic signed [hce_pkg::OUT_W-1:0]    rsp_tan_x,
   output logic signed [hce_pkg::OUT_W-1:0]    rsp_tan_y,
   output logic signed [hce_pkg::OUT_W-1:0]    rsp_curvature,
   output logic                                rsp_curvature_valid,
   output logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hce_pkg::PADDR_W-1:0]         paddr,
   input  logic [hce_pkg::COEF_W-1:0]          pwdata,
   output logic [hce_pkg::COEF_W-1:0]          prdata,
   output logic                                pready
);
   import hce_pkg::*;

`include "hermite_curve_2d_evaluator_macros.svh"

   // coefficient registers, word addressed
   logic [NUM_REGS-1:0][COEF_W-1:0] coef_ff;
   logic                            wr_en;

   logic                            poly_vld;
   logic signed [POS_W-1:0]         pos_w [2];
   logic signed [DER_W-1:0]         tan_w [2];
   logic signed [DER_W-1:0]         acc_w [2];

   crv_side_type                    cross_side;
   crv_side_type                    sqrt_side;
   logic [ROOT_W-1:0]               sqrt_root;

   logic                            div_vld;
   logic signed [OUT_W-1:0]         div_curv;
   logic                            div_cval;
   logic                            div_csat;

   logic [OUT_W:0]                  sat_px;
   logic [OUT_W:0]                  sat_py;
   logic [OUT_W:0]                  sat_tx;
   logic [OUT_W:0]                  sat_ty;
   kin_type                         kin_in;
   kin_type                         tap_ff [CURV_LAT];

   logic                            rsp_valid_ff;
   kin_type                         rsp_kin_ff;
   logic signed [OUT_W-1:0]         rsp_curv_ff;
   logic                            rsp_cval_ff;
   logic                            rsp_sat_ff;

   // ---------------------------------------------------------------
   // Configuration port: zero-wait writes, combinational read-back
   // ---------------------------------------------------------------
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign prdata = coef_ff[paddr[PADDR_W-1:2]];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (wr_en) begin
         coef_ff[paddr[PADDR_W-1:2]] <= pwdata;
      end
   end

   // Every item enters the pipeline at once; nothing ever holds it back.
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // Polynomial stages: position, tangent and second derivative
   // ---------------------------------------------------------------
   hce_poly u_poly (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start && !busy),
      .in_s    (req_s_param),
      .coef    (coef_ff),
      .out_vld (poly_vld),
      .pos     (pos_w),
      .tan     (tan_w),
      .acc     (acc_w)
   );

   // ---------------------------------------------------------------
   // Curvature: cross product and speed squared, root, then divide.
   // The unclipped derivatives feed this path.
   // ---------------------------------------------------------------
   hce_cross u_cross (
      .clock  (clock),
      .reset  (reset),
      .in_vld (poly_vld),
      .tan    (tan_w),
      .acc    (acc_w),
      .side   (cross_side)
   );

   hce_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_side  (cross_side),
      .out_side (sqrt_side),
      .root     (sqrt_root)
   );

   hce_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_side    (sqrt_side),
      .root       (sqrt_root),
      .out_vld    (div_vld),
      .curv       (div_curv),
      .curv_valid (div_cval),
      .curv_sat   (div_csat)
   );

   // ---------------------------------------------------------------
   // Clip position and tangent now, then hold them in a delay line
   // that matches the curvature path, so both halves of an item
   // leave together. The line advances every cycle.
   // ---------------------------------------------------------------
   always_comb begin
      sat_px     = sat32(pos_w[0]);
      sat_py     = sat32(pos_w[1]);
      sat_tx     = sat32(tan_w[0]);
      sat_ty     = sat32(tan_w[1]);
      kin_in.px  = sat_px[OUT_W-1:0];
      kin_in.py  = sat_py[OUT_W-1:0];
      kin_in.tx  = sat_tx[OUT_W-1:0];
      kin_in.ty  = sat_ty[OUT_W-1:0];
      kin_in.sat = sat_px[OUT_W] || sat_py[OUT_W] || sat_tx[OUT_W] || sat_ty[OUT_W];
   end

   always_ff @(posedge clock) begin
      tap_ff[0] <= kin_in;
      for (int k = 1; k < CURV_LAT; k++) begin
         tap_ff[k] <= tap_ff[k-1];
      end
   end

   // ---------------------------------------------------------------
   // Output register: merge both halves and strobe for one cycle
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kin_ff  <= tap_ff[CURV_LAT-1];
      rsp_curv_ff <= div_curv;
      rsp_cval_ff <= div_cval;
      rsp_sat_ff  <= tap_ff[CURV_LAT-1].sat || div_csat;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pos_x           = rsp_kin_ff.px;
   assign rsp_pos_y           = rsp_kin_ff.py;
   assign rsp_tan_x           = rsp_kin_ff.tx;
   assign rsp_tan_y           = rsp_kin_ff.ty;
   assign rsp_curvature       = rsp_curv_ff;
   assign rsp_curvature_valid = rsp_cval_ff;
   assign rsp_saturated       = rsp_sat_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `HCE_ASSERT_IMP(a_curv_zero_when_invalid, clock, reset, rsp_valid && !rsp_curvature_valid, rsp_curvature == '0, "curvature not zero while marked invalid")
   `HCE_ASSERT_IMP(a_moving_gives_curv, clock, reset, rsp_valid && (rsp_tan_x != '0 || rsp_tan_y != '0), rsp_curvature_valid, "nonzero tangent but curvature marked invalid")
   `HCE_ASSERT_NXT(a_csr_write_lands, clock, reset, psel && penable && pwrite, coef_ff[$past(paddr[PADDR_W-1:2])] == $past(pwdata), "coefficient write lost")

endmodule

>>> hw/rtl/hce_poly.sv
module hce_poly (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_vld,
   input  logic [hce_pkg::S_W-1:0]                        in_s,
   input  logic [hce_pkg::NUM_REGS-1:0][hce_pkg::COEF_W-1:0] coef,
   output logic                                           out_vld,
   output logic signed [hce_pkg::POS_W-1:0]               pos [2],
   output logic signed [hce_pkg::DER_W-1:0]               tan [2],
   output logic signed [hce_pkg::DER_W-1:0]               acc [2]
);
   import hce_pkg::*;

   localparam int AS_W = 48;
   localparam int H1_W = 49;
   localparam int G0_W = 51;
   localparam int G_W  = 42;
   localparam int A0_W = 51;
   localparam int H2_W = 65;
   localparam int TP_W = 58;
   localparam int H3_W = 43;
   localparam int HS_W = 58;

   localparam logic signed [G0_W-1:0] G_RND  = G0_W'(1) <<< 7;
   localparam logic signed [A0_W-1:0] A_RND  = A0_W'(1) <<< 14;
   localparam logic signed [H2_W-1:0] H2_RND = H2_W'(1) <<< 21;
   localparam logic signed [TP_W-1:0] TP_RND = TP_W'(1) <<< 21;
   localparam logic signed [HS_W-1:0] HS_RND = HS_W'(1) <<< 22;

   logic [POLY_LAT-1:0]       vld_ff;
   logic [S_W-1:0]            s_ff [5];
   logic [S_W-1:0]            s_in;

   logic signed [COEF_W-1:0]  ca [2];
   logic signed [COEF_W-1:0]  cb [2];
   logic signed [COEF_W-1:0]  cc [2];
   logic signed [COEF_W-1:0]  cd [2];

   logic signed [AS_W-1:0]    as_ff [2];
   logic signed [AS_W-1:0]    as_in [2];
   logic signed [H1_W-1:0]    h1_ff [2];
   logic signed [H1_W-1:0]    h1_in [2];
   logic signed [G0_W-1:0]    gs    [2];
   logic signed [G_W-1:0]     g_ff  [2];
   logic signed [G_W-1:0]     g_in  [2];
   logic signed [A0_W-1:0]    as6   [2];
   logic signed [DER_W-1:0]   acc_ff [5][2];
   logic signed [DER_W-1:0]   acc_in [2];
   logic signed [H2_W-1:0]    h2_ff [2];
   logic signed [H2_W-1:0]    h2_in [2];
   logic signed [TP_W-1:0]    tp_ff [2];
   logic signed [TP_W-1:0]    tp_in [2];
   logic signed [H3_W-1:0]    h3_ff [2];
   logic signed [H3_W-1:0]    h3_in [2];
   logic signed [DER_W-1:0]   tan_ff [3][2];
   logic signed [DER_W-1:0]   tan_in [2];
   logic signed [HS_W-1:0]    hs_ff [2];
   logic signed [HS_W-1:0]    hs_in [2];
   logic signed [POS_W-1:0]   pos_ff [2];
   logic signed [POS_W-1:0]   pos_in [2];

   always_comb begin
      ca[0] = coef[REG_X3];
      cb[0] = coef[REG_X2];
      cc[0] = coef[REG_X1];
      cd[0] = coef[REG_X0];
      ca[1] = coef[REG_Y3];
      cb[1] = coef[REG_Y2];
      cc[1] = coef[REG_Y1];
      cd[1] = coef[REG_Y0];

      s_in = (in_s > S_ONE) ? S_ONE : in_s;

      for (int i = 0; i < 2; i++) begin
         as_in[i] = AS_W'(ca[i]) * AS_W'($signed({1'b0, s_ff[0]}));

         h1_in[i] = H1_W'(as_ff[i]) + (H1_W'(cb[i]) <<< 15);
         gs[i]    = (G0_W'(as_ff[i]) <<< 1) + G0_W'(as_ff[i])
                    + (G0_W'(cb[i]) <<< 16) + G_RND;
         g_in[i]  = G_W'(gs[i] >>> 8);
         as6[i]   = (A0_W'(as_ff[i]) <<< 2) + (A0_W'(as_ff[i]) <<< 1)
                    + (A0_W'(cb[i]) <<< 16) + A_RND;
         acc_in[i] = DER_W'(as6[i] >>> 15);

         h2_in[i] = H2_W'(h1_ff[i]) * H2_W'($signed({1'b0, s_ff[2]}))
                    + (H2_W'(cc[i]) <<< 30);
         tp_in[i] = TP_W'(g_ff[i]) * TP_W'($signed({1'b0, s_ff[2]}))
                    + (TP_W'(cc[i]) <<< 22);

         h3_in[i]  = H3_W'((h2_ff[i] + H2_RND) >>> 22);
         tan_in[i] = DER_W'((tp_ff[i] + TP_RND) >>> 22);

         hs_in[i] = HS_W'(h3_ff[i]) * HS_W'($signed({1'b0, s_ff[4]}))
                    + (HS_W'(cd[i]) <<< 23);

         pos_in[i] = POS_W'((hs_ff[i] + HS_RND) >>> 23);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[POLY_LAT-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      s_ff[0] <= s_in;
      for (int k = 1; k < 5; k++) begin
         s_ff[k] <= s_ff[k-1];
      end
      as_ff     <= as_in;
      h1_ff     <= h1_in;
      g_ff      <= g_in;
      acc_ff[0] <= acc_in;
      for (int k = 1; k < 5; k++) begin
         acc_ff[k] <= acc_ff[k-1];
      end
      h2_ff     <= h2_in;
      tp_ff     <= tp_in;
      h3_ff     <= h3_in;
      tan_ff[0] <= tan_in;
      tan_ff[1] <= tan_ff[0];
      tan_ff[2] <= tan_ff[1];
      hs_ff     <= hs_in;
      pos_ff    <= pos_in;
   end

   always_comb begin
      out_vld = vld_ff[POLY_LAT-1];
      pos     = pos_ff;
      tan     = tan_ff[2];
      acc     = acc_ff[4];
   end

endmodule

>>> hw/rtl/hce_cross.sv
module hce_cross (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_vld,
   input  logic signed [hce_pkg::DER_W-1:0]  tan [2],
   input  logic signed [hce_pkg::DER_W-1:0]  acc [2],
   output hce_pkg::crv_side_type             side
);
   import hce_pkg::*;

   localparam int LO_W = 18;
   localparam int PL_W = DER_W + LO_W + 1;
   localparam int PH_W = 2 * DER_W - LO_W;

   logic signed [DER_W-1:0] opa [4];
   logic signed [DER_W-1:0] opb [4];
   logic signed [PL_W-1:0]  plo_ff [4];
   logic signed [PH_W-1:0]  phi_ff [4];
   logic signed [PL_W-1:0]  plo_in [4];
   logic signed [PH_W-1:0]  phi_in [4];
   logic signed [NUM_W-1:0] term [4];
   logic signed [NUM_W-1:0] n_ff;
   logic signed [NUM_W-1:0] n_in;
   logic signed [NUM_W-1:0] nabs;
   logic [SQ_W-1:0]         sq_ff;
   logic [SQ_W-1:0]         sq_in;
   logic [1:0]              vld_ff;
   logic [1:0]              zero_ff;
   crv_side_type            side_ff;

   // x'y'' , x''y' , x'x' , y'y'
   always_comb begin
      opa[0] = tan[0];
      opb[0] = acc[1];
      opa[1] = acc[0];
      opb[1] = tan[1];
      opa[2] = tan[0];
      opb[2] = tan[0];
      opa[3] = tan[1];
      opb[3] = tan[1];
      for (int k = 0; k < 4; k++) begin
         plo_in[k] = PL_W'(opa[k]) * PL_W'($signed({1'b0, opb[k][LO_W-1:0]}));
         phi_in[k] = PH_W'(opa[k]) * PH_W'($signed(opb[k][DER_W-1:LO_W]));
         term[k]   = (NUM_W'(phi_ff[k]) <<< LO_W) + NUM_W'(plo_ff[k]);
      end
      n_in  = term[0] - term[1];
      sq_in = SQ_W'(term[2] + term[3]);
      nabs  = n_ff[NUM_W-1] ? -n_ff : n_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         side_ff.vld <= 1'b0;
      end else begin
         vld_ff      <= {vld_ff[0], in_vld};
         side_ff.vld <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      zero_ff      <= {zero_ff[0], (tan[0] == '0) && (tan[1] == '0)};
      n_ff         <= n_in;
      sq_ff        <= sq_in;
      side_ff.zero <= zero_ff[1];
      side_ff.neg  <= n_ff[NUM_W-1];
      side_ff.mag  <= MAG_W'(nabs);
      side_ff.sq   <= sq_ff;
   end

   assign side = side_ff;

endmodule

>>> hw/rtl/hce_sqrt.sv
module hce_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  hce_pkg::crv_side_type         in_side,
   output hce_pkg::crv_side_type         out_side,
   output logic [hce_pkg::ROOT_W-1:0]    root
);
   import hce_pkg::*;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   crv_side_type      side_ff [ROOT_W];

   logic [REM_W-1:0]  rem_p   [ROOT_W];
   logic [ROOT_W-1:0] root_p  [ROOT_W];
   logic [RAD_W-1:0]  rad_p   [ROOT_W];
   crv_side_type      side_p  [ROOT_W];
   logic [REM_W-1:0]  sh      [ROOT_W];
   logic [REM_W-1:0]  trial   [ROOT_W];
   logic              ge      [ROOT_W];

   // one root bit per stage, radicand is S shifted up by 32
   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      if (k == 0) begin : g_first
         assign rem_p[k]  = '0;
         assign root_p[k] = '0;
         assign rad_p[k]  = {1'b0, in_side.sq, 32'b0};
         assign side_p[k] = in_side;
      end else begin : g_next
         assign rem_p[k]  = rem_ff[k-1];
         assign root_p[k] = root_ff[k-1];
         assign rad_p[k]  = rad_ff[k-1];
         assign side_p[k] = side_ff[k-1];
      end

      assign sh[k]    = {rem_p[k][REM_W-3:0], rad_p[k][RAD_W-1 -: 2]};
      assign trial[k] = {(REM_W-2)'(root_p[k]), 2'b01};
      assign ge[k]    = sh[k] >= trial[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k].vld <= 1'b0;
         end else begin
            side_ff[k].vld <= side_p[k].vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]       <= ge[k] ? (sh[k] - trial[k]) : sh[k];
         root_ff[k]      <= {root_p[k][ROOT_W-2:0], ge[k]};
         rad_ff[k]       <= rad_p[k] << 2;
         side_ff[k].zero <= side_p[k].zero;
         side_ff[k].neg  <= side_p[k].neg;
         side_ff[k].mag  <= side_p[k].mag;
         side_ff[k].sq   <= side_p[k].sq;
      end
   end

   assign out_side = side_ff[ROOT_W-1];
   assign root     = root_ff[ROOT_W-1];

endmodule

>>> hw/rtl/hce_div.sv
module hce_div (
   input  logic                                clock,
   input  logic                                reset,
   input  hce_pkg::crv_side_type               in_side,
   input  logic [hce_pkg::ROOT_W-1:0]          root,
   output logic                                out_vld,
   output logic signed [hce_pkg::OUT_W-1:0]    curv,
   output logic                                curv_valid,
   output logic                                curv_sat
);
   import hce_pkg::*;

   localparam int SC_W = 23;
   localparam int RC_W = 26;
   localparam int PP_W = SC_W + RC_W;

   typedef struct packed {
      logic vld;
      logic zero;
      logic neg;
      logic ovf;
   } div_ctl_type;

   logic [2*RC_W-1:0]    root_x;
   logic [PP_W-1:0]      pp_in  [6];
   logic [PP_W-1:0]      pp_ff  [6];
   crv_side_type         s1_ff;
   logic [DEN_W-1:0]     den_in;
   logic [DEN_W-1:0]     den2_ff;
   crv_side_type         s2_ff;
   logic [DIVREM_W-1:0]  rem0;

   logic [DIVREM_W-1:0]  rem_ff [Q_W+1];
   logic [DEN_W-1:0]     den_ff [Q_W+1];
   logic [Q_W-1:0]       q_ff   [Q_W+1];
   div_ctl_type          ctl_ff [Q_W+1];

   logic [DIVREM_W-1:0]  sh     [Q_W];
   logic [DIVREM_W-1:0]  dx     [Q_W];
   logic                 ge     [Q_W];

   logic [Q_W-1:0]       lim;
   logic                 over;
   logic [Q_W-1:0]       qs;
   logic [Q_W-1:0]       kval;
   logic                 vld_ff;
   logic [OUT_W-1:0]     curv_ff;
   logic                 cval_ff;
   logic                 csat_ff;

   // denominator S*r from six partial products
   always_comb begin
      root_x = (2*RC_W)'(root);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 2; j++) begin
            pp_in[i*2+j] = PP_W'(in_side.sq[i*SC_W +: SC_W]) * PP_W'(root_x[j*RC_W +: RC_W]);
         end
      end
      den_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 2; j++) begin
            den_in = den_in + (DEN_W'(pp_ff[i*2+j]) << (i*SC_W + j*RC_W));
         end
      end
      rem0 = DIVREM_W'({s2_ff.mag, 16'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld     <= 1'b0;
         s2_ff.vld     <= 1'b0;
         ctl_ff[0].vld <= 1'b0;
      end else begin
         s1_ff.vld     <= in_side.vld;
         s2_ff.vld     <= s1_ff.vld;
         ctl_ff[0].vld <= s2_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff          <= pp_in;
      s1_ff.zero     <= in_side.zero;
      s1_ff.neg      <= in_side.neg;
      s1_ff.mag      <= in_side.mag;
      s1_ff.sq       <= in_side.sq;
      den2_ff        <= den_in;
      s2_ff.zero     <= s1_ff.zero;
      s2_ff.neg      <= s1_ff.neg;
      s2_ff.mag      <= s1_ff.mag;
      s2_ff.sq       <= s1_ff.sq;
      rem_ff[0]      <= rem0;
      den_ff[0]      <= den2_ff;
      q_ff[0]        <= '0;
      ctl_ff[0].zero <= s2_ff.zero;
      ctl_ff[0].neg  <= s2_ff.neg;
      ctl_ff[0].ovf  <= rem0 >= DIVREM_W'(den2_ff);
   end

   // restoring divide, one quotient bit per stage; low dividend bits are zero
   for (genvar k = 0; k < Q_W; k++) begin : g_step
      assign sh[k] = {rem_ff[k][DIVREM_W-2:0], 1'b0};
      assign dx[k] = {1'b0, den_ff[k]};
      assign ge[k] = sh[k] >= dx[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1].vld <= 1'b0;
         end else begin
            ctl_ff[k+1].vld <= ctl_ff[k].vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]      <= ge[k] ? (sh[k] - dx[k]) : sh[k];
         den_ff[k+1]      <= den_ff[k];
         q_ff[k+1]        <= {q_ff[k][Q_W-2:0], ge[k]};
         ctl_ff[k+1].zero <= ctl_ff[k].zero;
         ctl_ff[k+1].neg  <= ctl_ff[k].neg;
         ctl_ff[k+1].ovf  <= ctl_ff[k].ovf;
      end
   end

   always_comb begin
      lim  = ctl_ff[Q_W].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      over = ctl_ff[Q_W].ovf || (q_ff[Q_W] > lim);
      qs   = over ? lim : q_ff[Q_W];
      kval = ctl_ff[Q_W].neg ? (~qs + 32'd1) : qs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= ctl_ff[Q_W].vld;
      end
   end

   always_ff @(posedge clock) begin
      curv_ff <= ctl_ff[Q_W].zero ? '0 : kval;
      cval_ff <= !ctl_ff[Q_W].zero;
      csat_ff <= !ctl_ff[Q_W].zero && over;
   end

   assign out_vld    = vld_ff;
   assign curv       = curv_ff;
   assign curv_valid = cval_ff;
   assign curv_sat   = csat_ff;

endmodule
